/* rtl/rpvd_pkg.sv */
package rpvd_pkg;

    localparam int COLUMN_BITS    = 12;
    localparam int ROW_BITS       = 12;
    localparam int VALUE_BITS     = 32;
    localparam int THRESHOLD_BITS = 31;
    localparam int BOUND_BITS     = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD          = 3'd0,
        REG_PEAK_GATE_ENABLE   = 3'd1,
        REG_PEAK_FLOOR         = 3'd2,
        REG_VALLEY_GATE_ENABLE = 3'd3,
        REG_VALLEY_CEILING     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [THRESHOLD_BITS-1:0] threshold;
        logic                      peak_gate_enable;
        logic [BOUND_BITS-1:0]     peak_floor;
        logic                      valley_gate_enable;
        logic [BOUND_BITS-1:0]     valley_ceiling;
    } cfg_t;

    typedef struct packed {
        logic                   is_valley;
        logic [COLUMN_BITS-1:0] column;
        logic [ROW_BITS-1:0]    row;
        logic [VALUE_BITS-1:0]  value;
    } result_t;

endpackage

/* rtl/row_peak_valley_detector.sv */
// A sample's request is taken into the input register, evaluated from there, and its
// peak or valley is registered in the result register that drives the result port.
// Throughput: one sample per clock; the input register and the result register
// stall together only while a pending result is not taken.
// Reset: asynchronous, active low; configuration clears to zero, search starts for a maximum.
module row_peak_valley_detector #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpvd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rpvd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic                                row_start,
    input  logic                                frame_start,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                is_valley,
    output logic [rpvd_pkg::COLUMN_BITS-1:0]    column,
    output logic [rpvd_pkg::ROW_BITS-1:0]       row,
    output logic [rpvd_pkg::VALUE_BITS-1:0]     value
);
    import rpvd_pkg::*;

    cfg_t    cfg;
    logic    advance;
    logic    event_valid;
    result_t event_data;

    rpvd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpvd_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .row_start    (row_start),
        .frame_start  (frame_start),
        .cfg          (cfg),
        .advance      (advance),
        .event_valid  (event_valid),
        .event_data   (event_data)
    );

    rpvd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_data   (event_data),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_valley    (is_valley),
        .column       (column),
        .row          (row),
        .value        (value)
    );

endmodule

/* rtl/rpvd_cfg.sv */
module rpvd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpvd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rpvd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output rpvd_pkg::cfg_t                      cfg
);
    import rpvd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:
                    cfg_next.threshold = cfg_data[THRESHOLD_BITS-1:0];
                REG_PEAK_GATE_ENABLE:
                    cfg_next.peak_gate_enable = cfg_data[0];
                REG_PEAK_FLOOR:
                    cfg_next.peak_floor = cfg_data[BOUND_BITS-1:0];
                REG_VALLEY_GATE_ENABLE:
                    cfg_next.valley_gate_enable = cfg_data[0];
                REG_VALLEY_CEILING:
                    cfg_next.valley_ceiling = cfg_data[BOUND_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/rpvd_core.sv */
module rpvd_core #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   row_start,
    input  logic                   frame_start,
    input  rpvd_pkg::cfg_t         cfg,
    input  logic                   advance,
    output logic                   event_valid,
    output rpvd_pkg::result_t      event_data
);
    import rpvd_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int VX = (SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
    localparam int AW = VX + 2;
    localparam int CX = (CW > COLUMN_BITS) ? CW : COLUMN_BITS;
    localparam int RX = (RW > ROW_BITS) ? RW : ROW_BITS;
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

    // Input register.
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          row_start_reg;
    logic                          frame_start_reg;

    // Detector state.
    logic signed [SAMPLE_BITS-1:0] max_value_reg, max_value_next;
    logic signed [SAMPLE_BITS-1:0] min_value_reg, min_value_next;
    logic [CW-1:0]                 max_column_reg, max_column_next;
    logic [CW-1:0]                 min_column_reg, min_column_next;
    logic [CW-1:0]                 column_count_reg, column_count_next;
    logic [RW-1:0]                 row_count_reg, row_count_next;
    logic                          seeking_max_reg, seeking_max_next;

    // Extremes after folding in the current sample.
    logic signed [SAMPLE_BITS-1:0] max_upd, min_upd;
    logic [CW-1:0]                 max_col_upd, min_col_upd;
    logic                          seek_upd;

    logic                  proc;
    logic                  line_start;
    logic signed [AW-1:0]  s_ext, thr_ext, max_ext, min_ext, max_reg_ext, min_reg_ext;
    logic signed [AW-1:0]  floor_ext, ceiling_ext;
    logic                  peak_hit, valley_hit, peak_ok, valley_ok;
    logic signed [VX-1:0]  max_wide, min_wide;
    logic [CX-1:0]         max_col_wide, min_col_wide;
    logic [RX-1:0]         row_wide;

    assign proc         = in_valid_reg && advance;
    assign sample_ready = !in_valid_reg || advance;
    assign line_start   = row_start_reg || frame_start_reg;

    assign s_ext       = AW'(sample_reg);
    assign thr_ext     = AW'(cfg.threshold);
    assign max_reg_ext = AW'(max_value_reg);
    assign min_reg_ext = AW'(min_value_reg);
    assign max_ext     = AW'(max_upd);
    assign min_ext     = AW'(min_upd);
    assign floor_ext   = AW'(signed'(cfg.peak_floor));
    assign ceiling_ext = AW'(signed'(cfg.valley_ceiling));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            sample_reg      <= sample;
            row_start_reg   <= row_start;
            frame_start_reg <= frame_start;
        end
    end

    // Position counters and running extremes.
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        seek_upd          = seeking_max_reg;
        if (frame_start_reg)
        begin
            row_count_next    = '0;
            column_count_next = '0;
            seek_upd          = 1'b1;
        end
        else if (row_start_reg)
        begin
            if (row_count_reg != ROW_LAST)
            begin
                row_count_next = row_count_reg + 1'b1;
            end
            column_count_next = '0;
        end
        else if (column_count_reg != COL_LAST)
        begin
            column_count_next = column_count_reg + 1'b1;
        end

        max_upd     = max_value_reg;
        max_col_upd = max_column_reg;
        min_upd     = min_value_reg;
        min_col_upd = min_column_reg;
        if (line_start)
        begin
            max_upd     = sample_reg;
            max_col_upd = column_count_next;
            min_upd     = sample_reg;
            min_col_upd = column_count_next;
        end
        else
        begin
            if (s_ext > max_reg_ext)
            begin
                max_upd     = sample_reg;
                max_col_upd = column_count_next;
            end
            if (s_ext < min_reg_ext)
            begin
                min_upd     = sample_reg;
                min_col_upd = column_count_next;
            end
        end
    end

    assign peak_hit   = seek_upd && (s_ext < (max_ext - thr_ext));
    assign valley_hit = !seek_upd && (s_ext > (min_ext + thr_ext));
    assign peak_ok    = (max_col_upd != '0) && (!cfg.peak_gate_enable || (max_ext > floor_ext));
    assign valley_ok  = (min_col_upd != '0)
                        && (!cfg.valley_gate_enable || (min_ext < ceiling_ext));

    // Hysteresis: a confirmed extreme flips the search direction and reseeds
    // the opposite extreme with the confirming sample.
    always_comb
    begin
        max_value_next   = max_upd;
        max_column_next  = max_col_upd;
        min_value_next   = min_upd;
        min_column_next  = min_col_upd;
        seeking_max_next = seek_upd;
        if (peak_hit)
        begin
            min_value_next   = sample_reg;
            min_column_next  = column_count_next;
            seeking_max_next = 1'b0;
        end
        else if (valley_hit)
        begin
            max_value_next   = sample_reg;
            max_column_next  = column_count_next;
            seeking_max_next = 1'b1;
        end
    end

    assign max_wide     = VX'(max_upd);
    assign min_wide     = VX'(min_upd);
    assign max_col_wide = CX'(max_col_upd);
    assign min_col_wide = CX'(min_col_upd);
    assign row_wide     = RX'(row_count_next);

    assign event_valid = proc && ((peak_hit && peak_ok) || (valley_hit && valley_ok));

    always_comb
    begin
        event_data.is_valley = valley_hit;
        event_data.row       = row_wide[ROW_BITS-1:0];
        if (valley_hit)
        begin
            event_data.column = min_col_wide[COLUMN_BITS-1:0];
            event_data.value  = min_wide[VALUE_BITS-1:0];
        end
        else
        begin
            event_data.column = max_col_wide[COLUMN_BITS-1:0];
            event_data.value  = max_wide[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg    <= '0;
            max_column_reg   <= '0;
            min_value_reg    <= '0;
            min_column_reg   <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            seeking_max_reg  <= 1'b1;
        end
        else if (proc)
        begin
            max_value_reg    <= max_value_next;
            max_column_reg   <= max_column_next;
            min_value_reg    <= min_value_next;
            min_column_reg   <= min_column_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            seeking_max_reg  <= seeking_max_next;
        end
    end

    // The first sample of a row seeds both extremes and cannot confirm anything.
    a_no_event_on_line_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc && line_start) |-> !event_valid)
        else $error("event raised on the first sample of a row");

    a_frame_start_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc && frame_start_reg) |=> (seeking_max_reg && (row_count_reg == '0)
                                       && (column_count_reg == '0)))
        else $error("frame start did not restore the search state");

    a_column_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        column_count_reg <= COL_LAST)
        else $error("column counter ran past the last column");

    a_state_holds_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        !proc |=> ($stable(seeking_max_reg) && $stable(column_count_reg)))
        else $error("detector state changed without a sample");

endmodule

/* rtl/rpvd_out.sv */
module rpvd_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                event_valid,
    input  rpvd_pkg::result_t                   event_data,
    output logic                                advance,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                is_valley,
    output logic [rpvd_pkg::COLUMN_BITS-1:0]    column,
    output logic [rpvd_pkg::ROW_BITS-1:0]       row,
    output logic [rpvd_pkg::VALUE_BITS-1:0]     value
);
    import rpvd_pkg::*;

    logic    result_valid_reg;
    result_t result_reg;

    // The stage moves whenever it is empty or its content is being taken.
    assign advance      = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign is_valley    = result_reg.is_valley;
    assign column       = result_reg.column;
    assign row          = result_reg.row;
    assign value        = result_reg.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= event_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && event_valid)
        begin
            result_reg <= event_data;
        end
    end

endmodule

/* test/row_peak_valley_detector_tb.sv */
module row_peak_valley_detector_tb;

    import rpvd_pkg::*;

    localparam int          MAX_COLUMNS = 4096;
    localparam int          MAX_ROWS    = 4096;
    localparam logic [11:0] COL_LAST    = 12'(MAX_COLUMNS - 1);
    localparam logic [11:0] ROW_LAST    = 12'(MAX_ROWS - 1);
    localparam int          IDLE_MAX    = 18;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          REPORT_CAP  = 100;
    // An index past the register map; a write there must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      sample_valid = 1'b0;
    logic                      sample_ready;
    logic [31:0]               sample       = '0;
    logic                      row_start    = 1'b0;
    logic                      frame_start  = 1'b0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    logic                      is_valley;
    logic [COLUMN_BITS-1:0]    column;
    logic [ROW_BITS-1:0]       row;
    logic [VALUE_BITS-1:0]     value;

    // Register copies for the extreme tracker.
    logic [THRESHOLD_BITS-1:0] cfg_threshold   = '0;
    logic                      cfg_peak_gate   = 1'b0;
    longint                    cfg_peak_floor  = 0;
    logic                      cfg_valley_gate = 1'b0;
    longint                    cfg_valley_ceil = 0;

    // Extreme tracker state.
    longint                    trk_max     = 0;
    logic [11:0]               trk_max_col = '0;
    longint                    trk_min     = 0;
    logic [11:0]               trk_min_col = '0;
    bit                        trk_seek_max = 1'b1;
    logic [11:0]               trk_col     = '0;
    logic [11:0]               trk_row     = '0;

    result_t                   events_due[$];
    result_t                   next_event;
    int                        mismatch_count = 0;
    int                        cycle_count    = 0;
    int unsigned               hold_request   = 0;
    bit                        tx_idle        = 1'b1;
    bit                        rx_idle        = 1'b1;

    row_peak_valley_detector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .row_start    (row_start),
        .frame_start  (frame_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_valley    (is_valley),
        .column       (column),
        .row          (row),
        .value        (value)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < REPORT_CAP)
            $display("Mismatch in %s: expected %h, got %h (cycle %0d)",
                     what, want, got, cycle_count);
        mismatch_count++;
    endtask

    // Works out the event, if any, that one accepted sample request causes.
    task automatic follow_extremes(input logic [31:0] s_bits, input logic rs,
                                   input logic fs);
        longint  s;
        longint  thr;
        result_t ev;
        s   = longint'($signed(s_bits));
        thr = longint'(cfg_threshold);

        if (fs)
        begin
            trk_row      = '0;
            trk_seek_max = 1'b1;
            trk_col      = '0;
        end
        else if (rs)
        begin
            if (trk_row < ROW_LAST)
                trk_row++;
            trk_col = '0;
        end
        else if (trk_col < COL_LAST)
        begin
            trk_col++;
        end

        if (fs || rs)
        begin
            trk_max     = s;
            trk_max_col = trk_col;
            trk_min     = s;
            trk_min_col = trk_col;
        end
        else
        begin
            if (s > trk_max)
            begin
                trk_max     = s;
                trk_max_col = trk_col;
            end
            if (s < trk_min)
            begin
                trk_min     = s;
                trk_min_col = trk_col;
            end
        end

        if (trk_seek_max)
        begin
            if (s < trk_max - thr)
            begin
                if (trk_max_col != 0 && (!cfg_peak_gate || trk_max > cfg_peak_floor))
                begin
                    ev.is_valley = 1'b0;
                    ev.column    = trk_max_col;
                    ev.row       = trk_row;
                    ev.value     = trk_max[31:0];
                    events_due.push_back(ev);
                end
                trk_min      = s;
                trk_min_col  = trk_col;
                trk_seek_max = 1'b0;
            end
        end
        else if (s > trk_min + thr)
        begin
            if (trk_min_col != 0 && (!cfg_valley_gate || trk_min < cfg_valley_ceil))
            begin
                ev.is_valley = 1'b1;
                ev.column    = trk_min_col;
                ev.row       = trk_row;
                ev.value     = trk_min[31:0];
                events_due.push_back(ev);
            end
            trk_max      = s;
            trk_max_col  = trk_col;
            trk_seek_max = 1'b1;
        end
    endtask

    task automatic send_sample(input logic [31:0] s, input logic rs, input logic fs);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        row_start    <= rs;
        frame_start  <= fs;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        follow_extremes(s, rs, fs);
    endtask

    // Stops offering samples and waits until every predicted event is out,
    // then waits out DRAIN_CYCLES for a sample still in flight that causes nothing.
    task automatic wait_for_events();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_THRESHOLD:          cfg_threshold   = data[THRESHOLD_BITS-1:0];
            REG_PEAK_GATE_ENABLE:   cfg_peak_gate   = data[0];
            REG_PEAK_FLOOR:         cfg_peak_floor  = longint'($signed(data));
            REG_VALLEY_GATE_ENABLE: cfg_valley_gate = data[0];
            REG_VALLEY_CEILING:     cfg_valley_ceil = longint'($signed(data));
            default:                ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] thr, input logic peak_gate,
                              input logic [31:0] floor_bits, input logic valley_gate,
                              input logic [31:0] ceil_bits);
        write_register(REG_THRESHOLD, thr);
        write_register(REG_PEAK_GATE_ENABLE, {31'(0), peak_gate});
        write_register(REG_PEAK_FLOOR, floor_bits);
        write_register(REG_VALLEY_GATE_ENABLE, {31'(0), valley_gate});
        write_register(REG_VALLEY_CEILING, ceil_bits);
    endtask

    // Reset configuration, and no row marker has been seen yet.
    task automatic test_no_row_start();
        send_sample(32'd5, 1'b0, 1'b0);
        send_sample(-32'sd5, 1'b0, 1'b0);
        send_sample(32'd5, 1'b0, 1'b0);
        send_sample(32'd9, 1'b0, 1'b0);
    endtask

    task automatic test_field_extremes();
        wait_for_events();
        set_config(32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
        send_sample(32'd0, 1'b1, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'd5, 1'b0, 1'b0);
        send_sample(32'd1, 1'b0, 1'b0);
        // The maximum sits at column zero: direction flips but nothing is reported.
        send_sample(32'd100, 1'b1, 1'b1);
        send_sample(32'd50, 1'b0, 1'b0);
        send_sample(32'd60, 1'b0, 1'b0);
        send_sample(32'd10, 1'b1, 1'b0);
        send_sample(32'd9, 1'b0, 1'b0);
        // A frame start in the middle of a valley search goes back to peaks.
        send_sample(32'd3, 1'b1, 1'b1);
        send_sample(32'd1, 1'b0, 1'b0);
        send_sample(32'd4, 1'b0, 1'b0);
    endtask

    task automatic test_gates();
        wait_for_events();
        set_config(32'd0, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(32'd0, 1'b1, 1'b1);
        send_sample(32'd11, 1'b0, 1'b0);
        send_sample(-32'sd11, 1'b0, 1'b0);
        send_sample(32'd10, 1'b0, 1'b0);
        send_sample(-32'sd10, 1'b0, 1'b0);
        wait_for_events();
        // Values right at the floor or ceiling fail the strict compare.
        set_config(32'd0, 1'b1, 32'd10, 1'b1, -32'sd10);
        send_sample(32'd0, 1'b1, 1'b1);
        send_sample(32'd11, 1'b0, 1'b0);
        send_sample(-32'sd11, 1'b0, 1'b0);
        send_sample(32'd10, 1'b0, 1'b0);
        send_sample(-32'sd10, 1'b0, 1'b0);
        send_sample(32'd11, 1'b0, 1'b0);
        send_sample(-32'sd11, 1'b0, 1'b0);
        send_sample(32'd5, 1'b0, 1'b0);
    endtask

    task automatic test_threshold_extremes();
        wait_for_events();
        // Bit 31 of the data has no place in the threshold register.
        set_config(32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 32'd0);
        send_sample(32'd0, 1'b1, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'd0, 1'b0, 1'b0);
    endtask

    // From the third sample on, every sample of the zigzag is an event, so a long hold
    // on the result side fills the block and it must stall the sample requests.
    task automatic test_back_pressure();
        wait_for_events();
        set_config(32'd0, 1'b0, 32'd0, 1'b0, 32'd0);
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 400;
        send_sample(32'd0, 1'b1, 1'b1);
        for (int i = 1; i <= 80; i++)
            send_sample((i % 2) ? $urandom_range(1, 1000) : -$urandom_range(1, 1000),
                        1'b0, 1'b0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        longint      level;
        longint      span;
        longint      delta;
        int unsigned sent;
        int unsigned row_len;
        logic [31:0] thr_bits;
        logic [31:0] floor_bits;
        logic [31:0] ceil_bits;
        logic [31:0] s_bits;
        logic        rs;
        logic        fs;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_for_events();
            case ($urandom_range(0, 4))
                0:       thr_bits = 32'd0;
                1:       thr_bits = $urandom_range(1, 100);
                2:       thr_bits = $urandom_range(0, 65535);
                3:       thr_bits = $urandom();
                default: thr_bits = 32'h7FFF_FFFF;
            endcase
            floor_bits = ($urandom_range(0, 2) == 0) ? $urandom()
                                                     : 32'($urandom_range(0, 2000)) - 1000;
            ceil_bits  = ($urandom_range(0, 2) == 0) ? $urandom()
                                                     : 32'($urandom_range(0, 2000)) - 1000;
            set_config(thr_bits, 1'($urandom_range(0, 1)), floor_bits,
                       1'($urandom_range(0, 1)), ceil_bits);
            sent  = 0;
            level = 0;
            while (sent < 100)
            begin
                row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 30);
                for (int k = 0; k < row_len && sent < 100; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        s_bits = $urandom();
                    end
                    else
                    begin
                        // Walk in steps on the scale of the threshold.
                        span = 2 * longint'(cfg_threshold) + 16;
                        if (span > 64'hFFFF_FFFF)
                            span = 64'hFFFF_FFFF;
                        delta = longint'($urandom_range(0, span[31:0]));
                        level = $urandom_range(0, 1) ? level + delta : level - delta;
                        if (level > 64'sh7FFF_FFFF)
                            level = 64'sh7FFF_FFFF;
                        if (level < -64'sh8000_0000)
                            level = -64'sh8000_0000;
                        s_bits = level[31:0];
                    end
                    rs = (k == 0);
                    fs = (k == 0) && (sent == 0 || $urandom_range(0, 7) == 0);
                    if ($urandom_range(0, 19) == 0)
                    begin
                        rs = 1'($urandom_range(0, 1));
                        fs = 1'($urandom_range(0, 1));
                    end
                    if (sent % 40 == 0)
                    begin
                        tx_idle = ($urandom_range(0, 3) != 0);
                        rx_idle = ($urandom_range(0, 3) != 0);
                    end
                    send_sample(s_bits, rs, fs);
                    sent++;
                end
            end
        end
    endtask

    // Result side: draws a wait for every event while rx_idle is set and takes one long hold on request.
    initial
    begin : result_receiver
        int unsigned wait_cycles;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        result_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (hold_request != 0)
                begin
                    wait_cycles  = hold_request;
                    hold_request = 0;
                end
                else
                begin
                    wait_cycles = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
                end
                if (wait_cycles != 0)
                begin
                    result_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                    result_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (events_due.size() == 0)
            begin
                report_mismatch("unexpected event value", 32'd0, value);
            end
            else
            begin
                next_event = events_due.pop_front();
                if (is_valley !== next_event.is_valley)
                    report_mismatch("is_valley", 32'(next_event.is_valley), 32'(is_valley));
                if (column !== next_event.column)
                    report_mismatch("column", 32'(next_event.column), 32'(column));
                if (row !== next_event.row)
                    report_mismatch("row", 32'(next_event.row), 32'(row));
                if (value !== next_event.value)
                    report_mismatch("value", next_event.value, value);
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_row_start();
        test_field_extremes();
        test_gates();
        test_threshold_extremes();
        test_back_pressure();
        test_random_frames();
        wait_for_events();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
